>>> rtl/rlbd_pkg.sv
// Package of shared types and constants for the run-length byte decoder.
package rlbd_pkg;

  localparam int LANE_FIELDS     = 4;
  localparam int DEF_OUT_LANES   = 4;
  localparam int DEF_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  count;
    logic        frame_end;
    logic        truncated;
    logic [15:0] total;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/rlbd_in_if.sv
// Input channel carrying one compressed byte per beat.
interface rlbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source(output valid, in_byte, frame_end, input ready);
  modport sink(input valid, in_byte, frame_end, output ready);
endinterface

>>> rtl/rlbd_out_if.sv
// Output channel carrying up to four decoded bytes and frame status per beat.
interface rlbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  lane0;
  logic [7:0]  lane1;
  logic [7:0]  lane2;
  logic [7:0]  lane3;
  logic [2:0]  lanes_valid;
  logic        last_of_item;
  logic        frame_done;
  logic        truncated;
  logic [15:0] frame_bytes;

  modport source(output valid, lane0, lane1, lane2, lane3, lanes_valid, last_of_item,
                 frame_done, truncated, frame_bytes, input ready);
  modport sink(input valid, lane0, lane1, lane2, lane3, lanes_valid, last_of_item,
               frame_done, truncated, frame_bytes, output ready);
endinterface

>>> rtl/run_length_byte_decoder.sv
// Top level of the run-length byte decoder.
// Decodes a PackBits-style byte stream, one compressed byte per input beat, into output
// beats of up to OUT_LANES (1 to 4) decoded bytes. Header and literal bytes are taken at one
// per cycle; a repeat value of n copies becomes ceil(n/OUT_LANES) sequencer beats, one per
// cycle unless the output stalls; the input stalls once the QUEUE_DEPTH-entry command queue
// between the front end and the sequencer is full. A frame-end byte yields a closing beat
// with the saturating decoded byte count and a flag if the frame ended inside a code.
module run_length_byte_decoder #(
  parameter int OUT_LANES   = rlbd_pkg::DEF_OUT_LANES,
  parameter int QUEUE_DEPTH = rlbd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  rlbd_in_if.sink     in_ch,
  rlbd_out_if.source  out_ch
);

  rlbd_pkg::cmd_t          push_cmd;
  rlbd_pkg::cmd_t          head;
  rlbd_pkg::queue_status_t q_status;
  logic                    push;
  logic                    pop;

  rlbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  rlbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  rlbd_back #(
    .OUT_LANES (OUT_LANES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/rlbd_front.sv
// Front end: accepts compressed bytes, tracks the code phase and queues output commands.
module rlbd_front (
  input  logic                 clk,
  input  logic                 rst,
  rlbd_in_if.sink              in_ch,
  input  rlbd_pkg::queue_status_t q_status,
  output logic                 push,
  output rlbd_pkg::cmd_t       cmd
);

  rlbd_pkg::phase_t phase, phase_next;
  logic [7:0]  pending, pending_next;
  logic [15:0] total, total_next;
  logic [7:0]  nbytes;
  logic [16:0] sum;
  logic        in_fire;

  assign in_ch.ready = !q_status.full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    nbytes       = 8'd0;
    phase_next   = rlbd_pkg::PH_HEADER;
    pending_next = 8'd0;
    unique case (phase)
      rlbd_pkg::PH_REPEAT: begin
        nbytes = pending;
      end
      rlbd_pkg::PH_LITERAL: begin
        nbytes = 8'd1;
        if (pending > 8'd1) begin
          pending_next = pending - 8'd1;
          phase_next   = rlbd_pkg::PH_LITERAL;
        end
      end
      default: begin
        if (in_ch.in_byte[7]) begin
          pending_next = 8'(9'd257 - {1'b0, in_ch.in_byte});
          phase_next   = rlbd_pkg::PH_REPEAT;
        end else begin
          pending_next = in_ch.in_byte + 8'd1;
          phase_next   = rlbd_pkg::PH_LITERAL;
        end
      end
    endcase
    sum        = {1'b0, total} + {9'd0, nbytes};
    total_next = sum[16] ? 16'hFFFF : sum[15:0];
  end

  assign push          = in_fire && ((nbytes != 8'd0) || in_ch.frame_end);
  assign cmd.value     = in_ch.in_byte;
  assign cmd.count     = nbytes;
  assign cmd.frame_end = in_ch.frame_end;
  assign cmd.truncated = in_ch.frame_end && (phase_next != rlbd_pkg::PH_HEADER);
  assign cmd.total     = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rlbd_pkg::PH_HEADER;
      pending <= 8'd0;
      total   <= 16'd0;
    end else if (in_fire) begin
      if (in_ch.frame_end) begin
        phase   <= rlbd_pkg::PH_HEADER;
        pending <= 8'd0;
        total   <= 16'd0;
      end else begin
        phase   <= phase_next;
        pending <= pending_next;
        total   <= total_next;
      end
    end
  end

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.frame_end |=> phase == rlbd_pkg::PH_HEADER && total == 16'd0)
    else $error("frame end did not restart the decoder");

endmodule

>>> rtl/rlbd_queue.sv
// Short command queue between the front end and the output sequencer.
module rlbd_queue #(
  parameter int DEPTH = rlbd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rlbd_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output rlbd_pkg::cmd_t          head,
  output rlbd_pkg::queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rlbd_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("pop from an empty queue");

endmodule

>>> rtl/rlbd_back.sv
// Output sequencer: splits each queued command into lane beats behind an output register.
module rlbd_back #(
  parameter int OUT_LANES = rlbd_pkg::DEF_OUT_LANES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rlbd_pkg::queue_status_t q_status,
  input  rlbd_pkg::cmd_t          head,
  output logic                    pop,
  rlbd_out_if.source              out_ch
);

  localparam int LPR = (OUT_LANES < 1) ? 1 :
                       ((OUT_LANES > rlbd_pkg::LANE_FIELDS) ? rlbd_pkg::LANE_FIELDS : OUT_LANES);
  localparam logic [7:0] LPR8 = 8'(LPR);

  logic        busy;
  logic [7:0]  value;
  logic [7:0]  rem;
  logic        fe;
  logic        trunc;
  logic [15:0] total;

  logic        ov;
  logic [7:0]  lanes [rlbd_pkg::LANE_FIELDS];
  logic [2:0]  nvalid;
  logic        last_r, done_r, trunc_r;
  logic [15:0] bytes_r;

  logic        out_free, emit, last;
  logic [7:0]  nl;

  assign out_free = !ov || out_ch.ready;
  assign emit     = busy && out_free;
  assign nl       = (rem < LPR8) ? rem : LPR8;
  assign last     = (rem <= LPR8);
  assign pop      = !q_status.empty && (!busy || (emit && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (emit && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value <= head.value;
      rem   <= head.count;
      fe    <= head.frame_end;
      trunc <= head.truncated;
      total <= head.total;
    end else if (emit) begin
      rem <= rem - nl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_free) begin
      ov <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int j = 0; j < rlbd_pkg::LANE_FIELDS; j++) begin
        lanes[j] <= (8'(j) < nl) ? value : 8'd0;
      end
      nvalid  <= nl[2:0];
      last_r  <= last;
      done_r  <= fe && last;
      trunc_r <= fe && last && trunc;
      bytes_r <= (fe && last) ? total : 16'd0;
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.lane0        = lanes[0];
  assign out_ch.lane1        = lanes[1];
  assign out_ch.lane2        = lanes[2];
  assign out_ch.lane3        = lanes[3];
  assign out_ch.lanes_valid  = nvalid;
  assign out_ch.last_of_item = last_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.truncated    = trunc_r;
  assign out_ch.frame_bytes  = bytes_r;

  a_empty_cmd_is_frame_end: assert property (@(posedge clk) disable iff (rst)
    busy && rem == 8'd0 |-> fe)
    else $error("empty command outside a frame end");

endmodule

>>> tb/tb_run_length_byte_decoder.sv
// Self-checking testbench for the run-length byte decoder: frames, truncation and stalls.
`timescale 1ns / 1ps

module tb_run_length_byte_decoder;

  localparam int BEAT_LANES = (rlbd_pkg::DEF_OUT_LANES < 1) ? 1 :
                              (rlbd_pkg::DEF_OUT_LANES > rlbd_pkg::LANE_FIELDS) ?
                              rlbd_pkg::LANE_FIELDS : rlbd_pkg::DEF_OUT_LANES;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 52;

  typedef struct packed {
    logic [3:0][7:0] lane;
    logic [2:0]      lanes_valid;
    logic            last_of_item;
    logic            frame_done;
    logic            truncated;
    logic [15:0]     frame_bytes;
  } beat_t;

  class rle_scoreboard;
    rlbd_pkg::phase_t ph;
    logic [7:0] pend;
    logic [15:0] total;
    beat_t      expected_beats[$];
    int         errors;

    function new();
      ph = rlbd_pkg::PH_HEADER;
      pend = '0;
      total = '0;
      errors = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic fe);
      int unsigned nbytes;
      int unsigned nres;
      int unsigned remaining;
      int unsigned nl;
      int unsigned sum;
      logic trunc;
      beat_t r;
      nbytes = 0;
      trunc = 1'b0;
      case (ph)
        rlbd_pkg::PH_REPEAT: begin
          nbytes = pend;
          ph = rlbd_pkg::PH_HEADER;
          pend = '0;
        end
        rlbd_pkg::PH_LITERAL: begin
          nbytes = 1;
          if (pend <= 1) begin
            pend = '0;
            ph = rlbd_pkg::PH_HEADER;
          end else begin
            pend = pend - 8'd1;
          end
        end
        default: begin
          if (b[7]) begin
            pend = 8'(257 - int'(b));
            ph = rlbd_pkg::PH_REPEAT;
          end else begin
            pend = b + 8'd1;
            ph = rlbd_pkg::PH_LITERAL;
          end
        end
      endcase
      sum = int'(total) + nbytes;
      total = (sum > 65535) ? 16'hFFFF : sum[15:0];
      if (fe) trunc = (ph != rlbd_pkg::PH_HEADER);
      nres = (nbytes + BEAT_LANES - 1) / BEAT_LANES;
      if (nres == 0 && fe) nres = 1;
      remaining = nbytes;
      for (int k = 0; k < nres; k++) begin
        nl = (remaining < BEAT_LANES) ? remaining : BEAT_LANES;
        remaining -= nl;
        for (int j = 0; j < rlbd_pkg::LANE_FIELDS; j++) r.lane[j] = (j < nl) ? b : 8'd0;
        r.lanes_valid = 3'(nl);
        r.last_of_item = (k + 1 == nres);
        r.frame_done = fe && r.last_of_item;
        r.truncated = r.frame_done && trunc;
        r.frame_bytes = r.frame_done ? total : 16'd0;
        expected_beats.push_back(r);
      end
      if (fe) begin
        ph = rlbd_pkg::PH_HEADER;
        pend = '0;
        total = '0;
      end
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        $error("output beat with no expected beat waiting");
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      for (int j = 0; j < rlbd_pkg::LANE_FIELDS; j++)
        compare($sformatf("lane%0d", j), want.lane[j], got.lane[j]);
      compare("lanes_valid", want.lanes_valid, got.lanes_valid);
      compare("last_of_item", want.last_of_item, got.last_of_item);
      compare("frame_done", want.frame_done, got.frame_done);
      compare("truncated", want.truncated, got.truncated);
      compare("frame_bytes", want.frame_bytes, got.frame_bytes);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rlbd_in_if  in_ch();
  rlbd_out_if out_ch();

  run_length_byte_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rle_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int idle_cycles = 0;
  int items_sent = 0;
  logic [7:0] code_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
        long_hold_done <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : monitor
    beat_t got;
    logic any_beat;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      any_beat = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.in_byte, in_ch.frame_end);
      if (out_ch.valid && out_ch.ready) begin
        got.lane[0] = out_ch.lane0;
        got.lane[1] = out_ch.lane1;
        got.lane[2] = out_ch.lane2;
        got.lane[3] = out_ch.lane3;
        got.lanes_valid = out_ch.lanes_valid;
        got.last_of_item = out_ch.last_of_item;
        got.frame_done = out_ch.frame_done;
        got.truncated = out_ch.truncated;
        got.frame_bytes = out_ch.frame_bytes;
        sb.check_beat(got);
      end
      if (any_beat) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fe);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.frame_end <= fe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_frame();
    int ncodes;
    int len;
    int cut;
    int sel;
    logic [7:0] hdr;
    code_bytes.delete();
    sel = $urandom_range(9);
    if (sel == 0) begin
      repeat ($urandom_range(8, 1)) code_bytes.push_back(8'($urandom));
    end else begin
      ncodes = $urandom_range(5, 1);
      repeat (ncodes) begin
        if ($urandom_range(1)) begin
          case ($urandom_range(9))
            0: hdr = 8'h80;
            1: hdr = 8'hFF;
            default: hdr = 8'(257 - $urandom_range(12, 2));
          endcase
          code_bytes.push_back(hdr);
          code_bytes.push_back(8'($urandom));
        end else begin
          len = ($urandom_range(29) == 0) ? 128 : $urandom_range(6, 1);
          code_bytes.push_back(8'(len - 1));
          repeat (len) code_bytes.push_back(8'($urandom));
        end
      end
    end
    cut = code_bytes.size() - 1;
    if (sel == 1) cut = $urandom_range(code_bytes.size() - 1, 0);
    for (int i = 0; i <= cut; i++) send_byte(code_bytes[i], i == cut);
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct);
    int target;
    wait_drained();
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) send_random_frame();
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'd0;
    in_ch.frame_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h81, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'hFD, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h84, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h85, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h7F, 1'b1);

    run_random_phase(0, 0);
    run_random_phase(46, 0);
    run_random_phase(0, 46);
    run_random_phase(15, 15);

    wait_drained();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    long_hold_req <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      send_byte(8'h80, 1'b0);
      send_byte(8'($urandom), k == 5);
    end
    while (!long_hold_done) @(posedge clk);
    long_hold_req <= 1'b0;

    wait_drained();
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> run_length_byte_decoder.f
rtl/rlbd_pkg.sv
rtl/rlbd_in_if.sv
rtl/rlbd_out_if.sv
rtl/rlbd_front.sv
rtl/rlbd_queue.sv
rtl/rlbd_back.sv
rtl/run_length_byte_decoder.sv
tb/tb_run_length_byte_decoder.sv
